@@ sv/lef_pkg.sv @@
package lef_pkg;

   // fixed field widths of the stream and register ports
   localparam int PIXEL_FIELD_BITS = 8;
   localparam int EDGE_BITS        = 11;
   localparam int WIDTH_REG_BITS   = 11;
   localparam int HEIGHT_REG_BITS  = 13;
   localparam int ROW_BITS         = 12;
   localparam int CSR_INDEX_BITS   = 8;
   localparam int CSR_DATA_BITS    = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_BITS'(1);

   // register reset values and legal ranges
   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = WIDTH_REG_BITS'(256);
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = HEIGHT_REG_BITS'(256);
   localparam int MIN_DIM      = 3;
   localparam int HEIGHT_LIMIT = 4096;

   // window geometry
   localparam int WINDOW_TAPS = 6;
   localparam int BORDER      = 2;

   // defaults for the top-level parameters and the queue depth
   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_PIXEL_BITS = 8;
   localparam int QUEUE_DEPTH        = 4;

endpackage

@@ sv/lef_req_if.sv @@
interface lef_req_if;
   import lef_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [PIXEL_FIELD_BITS-1:0] pixel_value;
   logic                        frame_start;

   modport source (output valid, output pixel_value, output frame_start, input ready);
   modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

@@ sv/lef_rsp_if.sv @@
interface lef_rsp_if;
   import lef_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [EDGE_BITS-1:0] edge_value;
   logic                 frame_last;

   modport source (output valid, output edge_value, output frame_last, input ready);
   modport sink   (input valid, input edge_value, input frame_last, output ready);
endinterface

@@ sv/lef_csr_if.sv @@
interface lef_csr_if;
   import lef_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/laplacian_edge_filter_3x3_core.sv @@
// path: an accepted pixel passes the queue, read stage, sum stage and output register
// throughput: one pixel per cycle unless the output stalls, line stores read ahead of write
// border pixels pass the queue and read stage and update the line stores but give no transaction
// reset: position, window and pipeline control cleared, frame size set to 256 x 256
// reset: line stores are not cleared; border rows fill them before they are read
module laplacian_edge_filter_3x3_core #(
   parameter int MAX_WIDTH  = lef_pkg::DEFAULT_MAX_WIDTH,
   parameter int PIXEL_BITS = lef_pkg::DEFAULT_PIXEL_BITS
) (
   input  logic      clock,
   input  logic      reset,
   lef_req_if.sink   req_stream,
   lef_csr_if.sink   csr_write,
   lef_rsp_if.source rsp_stream
);
   import lef_pkg::*;

   localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // one classified pixel as it travels from front to back
   typedef struct packed {
      logic [PIXEL_BITS-1:0] pix;
      logic [COL_BITS-1:0]   col;
      logic                  emit;
      logic                  frame_end;
   } item_type;

   logic     push, queue_full, q_valid, pop;
   item_type push_item, q_item;

   lef_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS),
      .item_type  (item_type)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .csr_write  (csr_write),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   lef_queue #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (item_type)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .pop       (pop)
   );

   lef_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS),
      .item_type  (item_type)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .pop        (pop),
      .rsp_stream (rsp_stream)
   );

endmodule

@@ sv/lef_front.sv @@
module lef_front #(
   parameter int  MAX_WIDTH  = lef_pkg::DEFAULT_MAX_WIDTH,
   parameter int  PIXEL_BITS = lef_pkg::DEFAULT_PIXEL_BITS,
   parameter type item_type  = logic
) (
   input  logic      clock,
   input  logic      reset,
   lef_req_if.sink   req_stream,
   lef_csr_if.sink   csr_write,
   input  logic      queue_full,
   output logic      push,
   output item_type  push_item
);
   import lef_pkg::*;

   localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int W_BITS   = (COL_BITS + 1 > WIDTH_REG_BITS) ? COL_BITS + 1 : WIDTH_REG_BITS;

   logic [WIDTH_REG_BITS-1:0]  image_width_ff, image_width_in;
   logic [HEIGHT_REG_BITS-1:0] image_height_ff, image_height_in;
   logic [COL_BITS-1:0]        col_pos_ff, col_pos_in;
   logic [ROW_BITS-1:0]        row_pos_ff, row_pos_in;

   logic [W_BITS-1:0]          width_raw, width_eff, last_col;
   logic [HEIGHT_REG_BITS-1:0] height_eff, last_row;
   logic [COL_BITS-1:0]        col_start, col_cur;
   logic [ROW_BITS-1:0]        row_cur;
   logic                       row_end, row_last;

   assign csr_write.ready  = 1'b1;
   assign req_stream.ready = !queue_full;
   assign push             = req_stream.valid && !queue_full;

   // register writes, out-of-list indexes are dropped
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write.valid) begin
         unique case (csr_write.index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_write.data[WIDTH_REG_BITS-1:0];
            CSR_IMAGE_HEIGHT: image_height_in = csr_write.data[HEIGHT_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective frame size, clamped to the legal range
   always_comb begin
      width_raw = W_BITS'(image_width_ff);
      if (width_raw < W_BITS'(MIN_DIM))        width_eff = W_BITS'(MIN_DIM);
      else if (width_raw > W_BITS'(MAX_WIDTH)) width_eff = W_BITS'(MAX_WIDTH);
      else                                     width_eff = width_raw;
      if (image_height_ff < HEIGHT_REG_BITS'(MIN_DIM))
         height_eff = HEIGHT_REG_BITS'(MIN_DIM);
      else if (image_height_ff > HEIGHT_REG_BITS'(HEIGHT_LIMIT))
         height_eff = HEIGHT_REG_BITS'(HEIGHT_LIMIT);
      else
         height_eff = image_height_ff;
      last_col = width_eff - W_BITS'(1);
      last_row = height_eff - HEIGHT_REG_BITS'(1);
   end

   // position of this pixel and its classification
   always_comb begin
      col_start = req_stream.frame_start ? '0 : col_pos_ff;
      row_cur   = req_stream.frame_start ? '0 : row_pos_ff;
      row_end   = (W_BITS'(col_start) >= last_col);
      col_cur   = row_end ? COL_BITS'(last_col) : col_start;
      row_last  = (HEIGHT_REG_BITS'(row_cur) >= last_row);

      push_item.pix       = PIXEL_BITS'(req_stream.pixel_value);
      push_item.col       = col_cur;
      push_item.emit      = (row_cur >= ROW_BITS'(BORDER)) && (col_cur >= COL_BITS'(BORDER));
      push_item.frame_end = row_end && row_last;

      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (push) begin
         if (row_end) begin
            col_pos_in = '0;
            row_pos_in = row_last ? '0 : row_cur + ROW_BITS'(1);
         end else begin
            col_pos_in = col_cur + COL_BITS'(1);
            row_pos_in = row_cur;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         col_pos_ff      <= '0;
         row_pos_ff      <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         col_pos_ff      <= col_pos_in;
         row_pos_ff      <= row_pos_in;
      end
   end

endmodule

@@ sv/lef_queue.sv @@
module lef_queue #(
   parameter int  DEPTH     = lef_pkg::QUEUE_DEPTH,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   output logic     q_valid,
   output item_type q_item,
   input  logic     pop
);
   import lef_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   item_type              slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = slot_ff[head_ff];

   // pointer and fill count update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_BITS'(DEPTH - 1)) ? '0 : tail_ff + PTR_BITS'(1);
      end
      if (pop) begin
         head_in = (head_ff == PTR_BITS'(DEPTH - 1)) ? '0 : head_ff + PTR_BITS'(1);
      end
      priority if (push && !pop) count_in = count_ff + CNT_BITS'(1);
      else if (pop && !push)     count_in = count_ff - CNT_BITS'(1);
      else                       count_in = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[tail_ff] <= push_item;
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue fill count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |=> count_ff == CNT_BITS'(DEPTH) && $stable(tail_ff))
      else $error("queue written while full");
`endif

endmodule

@@ sv/lef_back.sv @@
module lef_back #(
   parameter int  MAX_WIDTH  = lef_pkg::DEFAULT_MAX_WIDTH,
   parameter int  PIXEL_BITS = lef_pkg::DEFAULT_PIXEL_BITS,
   parameter type item_type  = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  item_type  q_item,
   output logic      pop,
   lef_rsp_if.source rsp_stream
);
   import lef_pkg::*;

   localparam int SUM_BITS = PIXEL_BITS + 3;

   // line stores, no reset
   logic [PIXEL_BITS-1:0] upper_mem  [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];

   // read stage
   logic                  s1_valid_ff, s1_valid_in;
   item_type              s1_item_ff;
   logic [PIXEL_BITS-1:0] upper_rd_ff, middle_rd_ff;
   logic                  byp_ff;
   logic [PIXEL_BITS-1:0] byp_top_ff, byp_mid_ff;
   logic [PIXEL_BITS-1:0] window_ff [WINDOW_TAPS];
   logic [PIXEL_BITS-1:0] top_eff, mid_eff;
   logic [SUM_BITS-1:0]   neigh_sum;
   logic                  s1_fire, s1_free, byp_in;

   // sum stage
   logic                  s2_valid_ff, s2_valid_in;
   logic [SUM_BITS-1:0]   s2_sum_ff;
   logic [PIXEL_BITS-1:0] s2_center_ff;
   logic                  s2_last_ff;
   logic                  s2_move, s2_free;
   logic [SUM_BITS-1:0]   center8, resp;

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic [EDGE_BITS-1:0]  out_edge_ff;
   logic                  out_last_ff;
   logic                  out_free;

   // pipeline flow control
   always_comb begin
      out_free = !out_valid_ff || rsp_stream.ready;
      s2_move  = s2_valid_ff && out_free;
      s2_free  = !s2_valid_ff || s2_move;
      s1_fire  = s1_valid_ff && (!s1_item_ff.emit || s2_free);
      s1_free  = !s1_valid_ff || s1_fire;
      pop      = q_valid && s1_free;
      byp_in   = s1_fire && (s1_item_ff.col == q_item.col);

      s1_valid_in  = pop ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s2_valid_in  = (s1_fire && s1_item_ff.emit) ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
      out_valid_in = s2_move ? 1'b1 : (rsp_stream.ready ? 1'b0 : out_valid_ff);
   end

   // line store data, forwarded when the previous pixel wrote the same column, and the neighbour sum
   always_comb begin
      top_eff   = byp_ff ? byp_top_ff : upper_rd_ff;
      mid_eff   = byp_ff ? byp_mid_ff : middle_rd_ff;
      neigh_sum = SUM_BITS'(window_ff[0]) + SUM_BITS'(window_ff[1])
                + SUM_BITS'(window_ff[2]) + SUM_BITS'(window_ff[3])
                + SUM_BITS'(window_ff[5]) + SUM_BITS'(top_eff)
                + SUM_BITS'(mid_eff) + SUM_BITS'(s1_item_ff.pix);
   end

   // rectified response
   always_comb begin
      center8 = SUM_BITS'(s2_center_ff) << 3;
      resp    = (s2_sum_ff > center8) ? '0 : center8 - s2_sum_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
         for (int i = 0; i < WINDOW_TAPS; i++) window_ff[i] <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         // forwarding flag lives with the pixel in the read stage
         if (pop)          byp_ff <= byp_in;
         else if (s1_fire) byp_ff <= 1'b0;
         if (s1_fire) begin
            window_ff[0] <= window_ff[3];
            window_ff[1] <= window_ff[4];
            window_ff[2] <= window_ff[5];
            window_ff[3] <= top_eff;
            window_ff[4] <= mid_eff;
            window_ff[5] <= s1_item_ff.pix;
         end
      end
   end

   // line store write and registered read
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         upper_mem[s1_item_ff.col]  <= mid_eff;
         middle_mem[s1_item_ff.col] <= s1_item_ff.pix;
      end
      if (pop) begin
         s1_item_ff   <= q_item;
         upper_rd_ff  <= upper_mem[q_item.col];
         middle_rd_ff <= middle_mem[q_item.col];
         byp_top_ff   <= mid_eff;
         byp_mid_ff   <= s1_item_ff.pix;
      end
   end

   // payload of the sum stage and output register
   always_ff @(posedge clock) begin
      if (s1_fire && s1_item_ff.emit) begin
         s2_sum_ff    <= neigh_sum;
         s2_center_ff <= window_ff[4];
         s2_last_ff   <= s1_item_ff.frame_end;
      end
      if (s2_move) begin
         out_edge_ff <= EDGE_BITS'(resp);
         out_last_ff <= s2_last_ff;
      end
   end

   assign rsp_stream.valid      = out_valid_ff;
   assign rsp_stream.edge_value = out_edge_ff;
   assign rsp_stream.frame_last = out_last_ff;

`ifndef SYNTH
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("read stage lost a stalled pixel");
   a_byp_owner: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> s1_valid_ff)
      else $error("forwarding flag set without a pixel in the read stage");
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_move |=> s2_valid_ff && $stable(s2_sum_ff))
      else $error("sum stage lost a stalled response");
`endif

endmodule

@@ tb/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lef_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 5;
   localparam int CYCLE_LIMIT     = 400_000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 20;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 280;
   localparam int COL_BITS        = $clog2(DEFAULT_MAX_WIDTH);
   localparam int CENTER_TAP      = 4;
   localparam int CENTER_GAIN     = 8;
   localparam int FIRST_UNMAPPED_CSR = int'(CSR_IMAGE_HEIGHT) + 1;
   localparam int LAST_CSR_INDEX     = 2 ** CSR_INDEX_BITS - 1;
   localparam logic [PIXEL_FIELD_BITS-1:0] PIXEL_BLACK = '0;
   localparam logic [PIXEL_FIELD_BITS-1:0] PIXEL_WHITE = '1;

   typedef enum int {PATTERN_UNIFORM, PATTERN_BINARY, PATTERN_FLAT} pixel_pattern_type;

   typedef struct {
      logic [EDGE_BITS-1:0] edge_value;
      logic                 frame_last;
   } edge_result_type;

   // laplacian predictor plus queue of expected edge transactions
   class edge_scoreboard;
      logic [WIDTH_REG_BITS-1:0]   width_reg;
      logic [HEIGHT_REG_BITS-1:0]  height_reg;
      logic [PIXEL_FIELD_BITS-1:0] upper_row [DEFAULT_MAX_WIDTH];
      logic [PIXEL_FIELD_BITS-1:0] middle_row [DEFAULT_MAX_WIDTH];
      logic [PIXEL_FIELD_BITS-1:0] window [WINDOW_TAPS];
      logic [COL_BITS-1:0]         col_pos;
      logic [ROW_BITS-1:0]         row_pos;
      edge_result_type             expected_edges [$];
      int                          failures;
      int                          pixels_seen;
      int                          edges_checked;
      int                          frame_ends;

      function new();
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
         end
         foreach (window[i]) window[i] = '0;
         col_pos       = '0;
         row_pos       = '0;
         failures      = 0;
         pixels_seen   = 0;
         edges_checked = 0;
         frame_ends    = 0;
      endfunction

      static function int unsigned bounded(int unsigned value, int unsigned lo, int unsigned hi);
         if (value < lo) return lo;
         if (value > hi) return hi;
         return value;
      endfunction

      function int unsigned frame_width();
         return bounded(32'(width_reg), MIN_DIM, DEFAULT_MAX_WIDTH);
      endfunction

      function int unsigned frame_height();
         return bounded(32'(height_reg), MIN_DIM, HEIGHT_LIMIT);
      endfunction

      function int pending();
         return expected_edges.size();
      endfunction

      // register write; unmapped indexes fall through
      function void write_reg(logic [CSR_INDEX_BITS-1:0] index,
                              logic [CSR_DATA_BITS-1:0] data);
         if (index == CSR_IMAGE_WIDTH) begin
            width_reg = data[WIDTH_REG_BITS-1:0];
         end else if (index == CSR_IMAGE_HEIGHT) begin
            height_reg = data[HEIGHT_REG_BITS-1:0];
         end
      endfunction

      // one accepted pixel: advance the window and queue any interior response
      function void note_pixel(logic [PIXEL_FIELD_BITS-1:0] pixel, logic frame_start);
         int unsigned                 w, h, col, row;
         logic [PIXEL_FIELD_BITS-1:0] top, mid;
         bit                          row_end, frame_end;
         int                          neighbors, response;
         edge_result_type             result;
         w = frame_width();
         h = frame_height();
         pixels_seen++;
         if (frame_start) begin
            col_pos = '0;
            row_pos = '0;
         end
         col = 32'(col_pos);
         row = 32'(row_pos);
         // a column past a shrunken width counts as the last one
         if (col >= w) col = w - 1;
         top       = upper_row[col];
         mid       = middle_row[col];
         row_end   = (col >= w - 1);
         frame_end = row_end && (row >= h - 1);

         if (row >= BORDER && col >= BORDER) begin
            neighbors = int'(top) + int'(mid) + int'(pixel);
            foreach (window[i]) begin
               if (i != CENTER_TAP) neighbors += int'(window[i]);
            end
            response = CENTER_GAIN * int'(window[CENTER_TAP]) - neighbors;
            if (response < 0) response = 0;
            result.edge_value = EDGE_BITS'(response);
            result.frame_last = frame_end;
            expected_edges.push_back(result);
         end

         upper_row[col]  = mid;
         middle_row[col] = pixel;
         window[0] = window[3];
         window[1] = window[4];
         window[2] = window[5];
         window[3] = top;
         window[4] = mid;
         window[5] = pixel;

         if (row_end) begin
            col_pos = '0;
            row_pos = (row >= h - 1) ? '0 : ROW_BITS'(row + 1);
         end else begin
            col_pos = COL_BITS'(col + 1);
         end
      endfunction

      // compare one edge transaction with the oldest expectation
      function void check_edge(logic [EDGE_BITS-1:0] edge_value, logic frame_last);
         edge_result_type want;
         if (expected_edges.size() == 0) begin
            $error("edge transaction with none expected: edge_value=%0d frame_last=%0d",
                   edge_value, frame_last);
            failures++;
            return;
         end
         want = expected_edges.pop_front();
         edges_checked++;
         if (want.frame_last) frame_ends++;
         if (edge_value !== want.edge_value) begin
            $error("edge_value mismatch: expected %0d, actual %0d", want.edge_value, edge_value);
            failures++;
         end
         if (frame_last !== want.frame_last) begin
            $error("frame_last mismatch: expected %0d, actual %0d", want.frame_last, frame_last);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   lef_req_if req_stream ();
   lef_csr_if csr_write ();
   lef_rsp_if rsp_stream ();

   edge_scoreboard board = new();

   int idle_percent    = 0;
   int stall_percent   = 0;
   int hold_off_cycles = 0;
   int cycle_count     = 0;
   int pixels_sent     = 0;
   int settings_made   = 0;

   laplacian_edge_filter_3x3_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .csr_write  (csr_write),
      .rsp_stream (rsp_stream)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d edge results outstanding",
                  cycle_count, board.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // sample every handshake at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write.valid && csr_write.ready) begin
            board.write_reg(csr_write.index, csr_write.data);
         end
         if (req_stream.valid && req_stream.ready) begin
            board.note_pixel(req_stream.pixel_value, req_stream.frame_start);
         end
         if (rsp_stream.valid && rsp_stream.ready) begin
            board.check_edge(rsp_stream.edge_value, rsp_stream.frame_last);
         end
      end
   end

   // result side: random stalls, or a long hold-off counted here
   initial begin
      rsp_stream.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stream.ready = 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_stream.ready = ($urandom_range(99) >= stall_percent);
         end
      end
   end

   // offer one pixel, with random idle cycles ahead of it
   task automatic send_pixel(input logic [PIXEL_FIELD_BITS-1:0] pixel, input logic frame_start);
      while ($urandom_range(99) < idle_percent) begin
         req_stream.valid = 1'b0;
         @(negedge clock);
      end
      req_stream.valid       = 1'b1;
      req_stream.pixel_value = pixel;
      req_stream.frame_start = frame_start;
      do @(posedge clock); while (!req_stream.ready);
      @(negedge clock);
      pixels_sent++;
   endtask

   // a run of pixels; only the first may carry frame_start
   task automatic send_pixels(input int count, input logic frame_start,
                              input pixel_pattern_type pattern);
      logic [PIXEL_FIELD_BITS-1:0] pixel;
      for (int i = 0; i < count; i++) begin
         case (pattern)
            PATTERN_BINARY: pixel = $urandom_range(1) ? PIXEL_WHITE : PIXEL_BLACK;
            PATTERN_FLAT:   pixel = PIXEL_FIELD_BITS'($urandom_range(136, 120));
            default:        pixel = PIXEL_FIELD_BITS'($urandom);
         endcase
         send_pixel(pixel, (i == 0) ? frame_start : 1'b0);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write.valid = 1'b1;
      csr_write.index = index;
      csr_write.data  = data;
      do @(posedge clock); while (!csr_write.ready);
      @(negedge clock);
      csr_write.valid = 1'b0;
   endtask

   // hold the sender until every expected result is in, then wait out the pipeline
   task automatic settle(input int extra);
      req_stream.valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] width_word,
                            input logic [CSR_DATA_BITS-1:0] height_word);
      settle(SETTLE_CYCLES);
      write_csr(CSR_IMAGE_WIDTH, width_word);
      write_csr(CSR_IMAGE_HEIGHT, height_word);
      settings_made++;
   endtask

   initial begin
      int                         phase_start, cols, rows, dim;
      bit                         restart;
      pixel_pattern_type          pattern;
      logic [CSR_DATA_BITS-1:0]   width_word, height_word;
      int                         phase_idle [4];
      int                         phase_stall [4];

      phase_idle  = '{0, 62, 0, 6};
      phase_stall = '{0, 0, 62, 6};

      req_stream.valid       = 1'b0;
      req_stream.pixel_value = '0;
      req_stream.frame_start = 1'b0;
      csr_write.valid        = 1'b0;
      csr_write.index        = '0;
      csr_write.data         = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset geometry: two full 256-pixel rows and the start of the third
      idle_percent  = 20;
      stall_percent = 20;
      send_pixels(2 * 256 + 3, 1'b1, PATTERN_UNIFORM);

      // out-of-range words clamp to the 3x3 minimum; unmapped indexes are ignored
      configure('0, CSR_DATA_BITS'(2));
      write_csr(CSR_INDEX_BITS'(FIRST_UNMAPPED_CSR), CSR_DATA_BITS'($urandom));
      write_csr(CSR_INDEX_BITS'(LAST_CSR_INDEX), CSR_DATA_BITS'($urandom));

      // bright center on black gives the largest response
      for (int i = 0; i < 9; i++) begin
         send_pixel((i == CENTER_TAP) ? PIXEL_WHITE : PIXEL_BLACK, i == 0);
      end
      // next frame relies on the position wrapping by itself; dark center clamps to zero
      for (int i = 0; i < 9; i++) begin
         send_pixel((i == CENTER_TAP) ? PIXEL_BLACK : PIXEL_WHITE, 1'b0);
      end
      // cut-off frame restarted by frame_start
      send_pixels(4, 1'b1, PATTERN_UNIFORM);
      send_pixels(9, 1'b1, PATTERN_UNIFORM);

      // word bits above the register masked off
      idle_percent  = 0;
      stall_percent = 0;
      configure(16'h0805, 16'hE006);
      send_pixels(5 * 6, 1'b1, PATTERN_UNIFORM);

      // width shrinks mid-row: the current column becomes the row end
      idle_percent  = 10;
      stall_percent = 10;
      configure(CSR_DATA_BITS'(6), CSR_DATA_BITS'(5));
      send_pixels(2 * 6 + 3, 1'b1, PATTERN_UNIFORM);
      settle(SETTLE_CYCLES);
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(4));
      send_pixels(1 + 2 * 4, 1'b0, PATTERN_UNIFORM);

      // height shrinks below the current row: this row ends the frame
      configure(CSR_DATA_BITS'(4), CSR_DATA_BITS'(7));
      send_pixels(5 * 4, 1'b1, PATTERN_UNIFORM);
      settle(SETTLE_CYCLES);
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(4));
      send_pixels(4, 1'b0, PATTERN_UNIFORM);

      // random frames under four idling profiles
      for (int phase = 0; phase < 4; phase++) begin
         idle_percent  = phase_idle[phase];
         stall_percent = phase_stall[phase];
         phase_start   = pixels_sent;
         restart       = 1'b1;
         if (phase == 0) hold_off_cycles = HOLD_OFF_CYCLES;
         while (pixels_sent - phase_start < PHASE_ITEMS) begin
            if (restart || $urandom_range(3) == 0) begin
               dim = ($urandom_range(9) == 0) ? $urandom_range(2, 0) :
                     ($urandom_range(7) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 3);
               width_word = CSR_DATA_BITS'(dim);
               if ($urandom_range(3) == 0) begin
                  width_word |= CSR_DATA_BITS'($urandom_range(31)) << WIDTH_REG_BITS;
               end
               dim = ($urandom_range(9) == 0) ? $urandom_range(2, 0) :
                     ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 3);
               height_word = CSR_DATA_BITS'(dim);
               if ($urandom_range(3) == 0) begin
                  height_word |= CSR_DATA_BITS'($urandom_range(7)) << HEIGHT_REG_BITS;
               end
               configure(width_word, height_word);
               if ($urandom_range(7) == 0) begin
                  write_csr(CSR_INDEX_BITS'($urandom_range(LAST_CSR_INDEX, FIRST_UNMAPPED_CSR)),
                            CSR_DATA_BITS'($urandom));
               end
               restart = 1'b1;
            end
            cols    = board.frame_width();
            rows    = board.frame_height();
            pattern = pixel_pattern_type'($urandom_range(2));
            if ($urandom_range(15) == 0) begin
               // broken frame; the next one restarts the position
               send_pixels($urandom_range(cols * rows - 1, 1), restart || $urandom_range(1),
                           pattern);
               restart = 1'b1;
            end else begin
               send_pixels(cols * rows, restart || $urandom_range(1), pattern);
               restart = 1'b0;
            end
            if ($urandom_range(9) == 0) settle(0);
         end
      end

      settle(DRAIN_CYCLES);
      $display("covered %0d pixels over %0d frame geometries: %0d edge results, %0d frame ends",
               board.pixels_seen, settings_made, board.edges_checked, board.frame_ends);
      $display("geometry from the 3x3 clamp to the 256 x 256 reset size, masked and unmapped "
               , "register writes, idle, stall and hold-off phases");
      if (board.failures == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ laplacian_edge_filter_3x3_core.f @@
sv/lef_pkg.sv
sv/lef_req_if.sv
sv/lef_rsp_if.sv
sv/lef_csr_if.sv
sv/lef_front.sv
sv/lef_queue.sv
sv/lef_back.sv
sv/laplacian_edge_filter_3x3_core.sv
tb/tb_top.sv
